/* rtl/core/kls_pkg.sv */
// kls_pkg: types and constants shared by the keyframe sampler modules
// no dependencies

package kls_pkg;

  localparam int TIME_W   = 32;
  localparam int VAL_W    = 32;
  localparam int KIDX_W   = 6;
  localparam int KCNT_W   = 7;
  localparam int FRAC_W   = 16;
  // dividend is the time offset magnitude shifted up by the fraction bits
  localparam int DVD_W    = TIME_W + FRAC_W;
  localparam int DIV_STEPS = DVD_W;
  localparam int DCNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic [KIDX_W-1:0]        key_index;
    logic [TIME_W-1:0]        key_time;
    logic signed [VAL_W-1:0]  value_x;
    logic signed [VAL_W-1:0]  value_y;
    logic signed [VAL_W-1:0]  value_z;
    logic [TIME_W-1:0]        sample_time;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  out_x;
    logic signed [VAL_W-1:0]  out_y;
    logic signed [VAL_W-1:0]  out_z;
    logic [KIDX_W-1:0]        segment_index;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] z;
  } vec3_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CMP,
    S_T0_RD,
    S_T0_CHK,
    S_DIV,
    S_FSAT,
    S_VA_RD,
    S_VB_LD,
    S_MUL,
    S_ADD,
    S_KEY_RD,
    S_KEY_OUT,
    S_RES_OUT
  } kls_state_t;

  typedef enum logic {
    ADDR_CUR,
    ADDR_NEXT
  } addr_sel_t;

  typedef struct packed {
    logic      key_wr;
    logic      start;
    addr_sel_t addr_sel;
    logic      idx_inc;
    logic      t1_ld;
    logic      div_start;
    logic      div_run;
    logic      fsat_ld;
    logic      a_ld;
    logic      b_ld;
    logic      mul;
    logic      acc;
    logic      emit_key;
    logic      emit_res;
  } kls_cmd_t;

  typedef struct packed {
    logic last_hit;
    logic next_le_t;
    logic t1_le_t0;
    logic div_done;
    logic comp_last;
    logic out_free;
  } kls_status_t;

endpackage

/* rtl/core/kls_dp.sv */
// kls_dp: key stores, walk index, serial divider, multiply/saturate and
// the output register of the keyframe sampler; uses kls_pkg

module kls_dp #(
  parameter int MAX_KEYS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kls_pkg::in_item_t           in_data,
  input  logic                        cfg_we,
  input  logic [kls_pkg::KCNT_W-1:0]  cfg_wdata,
  input  kls_pkg::kls_cmd_t           cmd,
  output kls_pkg::kls_status_t        status,
  output logic                        out_valid,
  input  logic                        out_stall,
  output kls_pkg::out_item_t          out_data
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  // key stores
  logic [kls_pkg::TIME_W-1:0] tmem [MAX_KEYS];
  kls_pkg::vec3_t             vmem [MAX_KEYS];
  logic [kls_pkg::TIME_W-1:0] tm_q_r;
  kls_pkg::vec3_t             vm_q_r;

  logic [AW+kls_pkg::KIDX_W-1:0] widx_wide;
  logic [AW-1:0]                 waddr;
  logic                          wr_ok;
  logic [AW-1:0]                 raddr;
  kls_pkg::vec3_t                wval;

  logic [kls_pkg::KCNT_W-1:0] key_count_r;
  logic [31:0]                kc32;
  logic [AW-1:0]              last_idx;

  logic [AW-1:0]              i_r;
  logic [kls_pkg::TIME_W-1:0] t_r;
  logic [kls_pkg::TIME_W-1:0] t1_r;
  logic                       sat_r;

  // divider
  logic [kls_pkg::TIME_W-1:0] d_r;
  logic [kls_pkg::TIME_W-1:0] rem_r;
  logic [kls_pkg::DVD_W-1:0]  dvd_r;
  logic                       neg_r;
  logic [kls_pkg::DCNT_W-1:0] cnt_r;
  logic [kls_pkg::TIME_W:0]   rem_sh;
  logic [kls_pkg::TIME_W:0]   rem_sub;
  logic                       q_bit;
  logic [kls_pkg::TIME_W:0]   tdiff;
  logic [kls_pkg::TIME_W:0]   tmag;

  // factor and components
  logic signed [kls_pkg::VAL_W-1:0] f_r;
  logic signed [kls_pkg::VAL_W-1:0] f_nxt;
  logic                             f_sat;
  kls_pkg::vec3_t                   a_r;
  kls_pkg::vec3_t                   b_r;
  logic [1:0]                       comp_r;
  logic signed [kls_pkg::VAL_W-1:0] a_c;
  logic signed [kls_pkg::VAL_W-1:0] b_c;
  logic signed [kls_pkg::VAL_W:0]   diff_c;
  logic signed [2*kls_pkg::VAL_W:0] prod_nxt;
  logic signed [2*kls_pkg::VAL_W:0] prod_r;
  logic [2*kls_pkg::VAL_W-kls_pkg::FRAC_W:0] sh_c;
  logic [2*kls_pkg::VAL_W-kls_pkg::FRAC_W+1:0] sum_c;
  logic                             sum_ovf;
  logic signed [kls_pkg::VAL_W-1:0] res_c;
  logic signed [kls_pkg::VAL_W-1:0] res_r [3];

  logic [AW+kls_pkg::KIDX_W-1:0] seg_wide;
  logic [kls_pkg::KIDX_W-1:0]    seg;

  logic                out_valid_r;
  kls_pkg::out_item_t  out_data_r;

  // write side
  always_comb begin
    widx_wide = (AW + kls_pkg::KIDX_W)'(in_data.key_index);
    waddr     = widx_wide[AW-1:0];
    wr_ok     = cmd.key_wr && (32'(in_data.key_index) < 32'(MAX_KEYS));
    wval.x    = in_data.value_x;
    wval.y    = in_data.value_y;
    wval.z    = in_data.value_z;
    raddr     = (cmd.addr_sel == kls_pkg::ADDR_NEXT) ? (i_r + AW'(1)) : i_r;
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      tmem[waddr] <= in_data.key_time;
      vmem[waddr] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    tm_q_r <= tmem[raddr];
    vm_q_r <= vmem[raddr];
  end

  // key count register, clamped to 1..MAX_KEYS and used as last index 0..MAX_KEYS-1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= kls_pkg::KCNT_W'(1);
    end else if (cfg_we) begin
      key_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    kc32 = 32'(key_count_r);
    if (kc32 == 32'd0) begin
      last_idx = '0;
    end else if (kc32 > 32'(MAX_KEYS)) begin
      last_idx = AW'(MAX_KEYS - 1);
    end else begin
      last_idx = AW'(kc32 - 32'd1);
    end
  end

  // divider step and operand setup
  always_comb begin
    rem_sh  = {rem_r, dvd_r[kls_pkg::DVD_W-1]};
    rem_sub = rem_sh - {1'b0, d_r};
    q_bit   = (rem_sh >= {1'b0, d_r});
    tdiff   = {1'b0, t_r} - {1'b0, tm_q_r};
    tmag    = tdiff[kls_pkg::TIME_W] ? ((kls_pkg::TIME_W+1)'(0) - tdiff) : tdiff;
  end

  // factor saturation, truncation toward zero comes from the magnitude divide
  always_comb begin
    f_sat = 1'b0;
    if (!neg_r) begin
      if (dvd_r > kls_pkg::DVD_W'(32'h7FFF_FFFF)) begin
        f_nxt = 32'sh7FFF_FFFF;
        f_sat = 1'b1;
      end else begin
        f_nxt = dvd_r[kls_pkg::VAL_W-1:0];
      end
    end else begin
      if (dvd_r > kls_pkg::DVD_W'(32'h8000_0000)) begin
        f_nxt = 32'sh8000_0000;
        f_sat = 1'b1;
      end else begin
        f_nxt = 32'd0 - dvd_r[kls_pkg::VAL_W-1:0];
      end
    end
  end

  // component lane select
  always_comb begin
    case (comp_r)
      2'd0: begin
        a_c = a_r.x;
        b_c = b_r.x;
      end
      2'd1: begin
        a_c = a_r.y;
        b_c = b_r.y;
      end
      default: begin
        a_c = a_r.z;
        b_c = b_r.z;
      end
    endcase
    diff_c   = {b_c[kls_pkg::VAL_W-1], b_c} - {a_c[kls_pkg::VAL_W-1], a_c};
    prod_nxt = f_r * diff_c;
    // arithmetic shift gives the floor of the division by 2^16
    sh_c     = prod_r[2*kls_pkg::VAL_W:kls_pkg::FRAC_W];
    sum_c    = {sh_c[2*kls_pkg::VAL_W-kls_pkg::FRAC_W], sh_c}
             + {{(kls_pkg::VAL_W-kls_pkg::FRAC_W+2){a_c[kls_pkg::VAL_W-1]}}, a_c};
    sum_ovf  = (sum_c[2*kls_pkg::VAL_W-kls_pkg::FRAC_W+1:kls_pkg::VAL_W-1]
                != {(kls_pkg::VAL_W-kls_pkg::FRAC_W+3){sum_c[2*kls_pkg::VAL_W-kls_pkg::FRAC_W+1]}});
    if (sum_ovf) begin
      res_c = sum_c[2*kls_pkg::VAL_W-kls_pkg::FRAC_W+1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      res_c = sum_c[kls_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      t_r <= in_data.sample_time;
      i_r <= '0;
    end else if (cmd.idx_inc) begin
      i_r <= i_r + AW'(1);
    end
    if (cmd.t1_ld) begin
      t1_r <= tm_q_r;
    end
    if (cmd.div_start) begin
      d_r   <= t1_r - tm_q_r;
      rem_r <= '0;
      dvd_r <= {tmag[kls_pkg::TIME_W-1:0], {kls_pkg::FRAC_W{1'b0}}};
      neg_r <= tdiff[kls_pkg::TIME_W];
    end else if (cmd.div_run) begin
      rem_r <= q_bit ? rem_sub[kls_pkg::TIME_W-1:0] : rem_sh[kls_pkg::TIME_W-1:0];
      dvd_r <= {dvd_r[kls_pkg::DVD_W-2:0], q_bit};
    end
    if (cmd.fsat_ld) begin
      f_r <= f_nxt;
    end
    if (cmd.a_ld) begin
      a_r <= vm_q_r;
    end
    if (cmd.b_ld) begin
      b_r <= vm_q_r;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc) begin
      res_r[comp_r] <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sat_r  <= 1'b0;
      comp_r <= '0;
    end else begin
      if (cmd.div_start) begin
        cnt_r <= kls_pkg::DCNT_W'(kls_pkg::DIV_STEPS);
      end else if (cmd.div_run) begin
        cnt_r <= cnt_r - kls_pkg::DCNT_W'(1);
      end
      if (cmd.start) begin
        sat_r <= 1'b0;
      end else if ((cmd.fsat_ld && f_sat) || (cmd.acc && sum_ovf)) begin
        sat_r <= 1'b1;
      end
      if (cmd.b_ld) begin
        comp_r <= '0;
      end else if (cmd.acc) begin
        comp_r <= comp_r + 2'd1;
      end
    end
  end

  // output register
  always_comb begin
    seg_wide = (AW + kls_pkg::KIDX_W)'(i_r);
    seg      = seg_wide[kls_pkg::KIDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_key || cmd.emit_res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_key) begin
      out_data_r.out_x         <= vm_q_r.x;
      out_data_r.out_y         <= vm_q_r.y;
      out_data_r.out_z         <= vm_q_r.z;
      out_data_r.segment_index <= seg;
      out_data_r.saturated     <= 1'b0;
    end else if (cmd.emit_res) begin
      out_data_r.out_x         <= res_r[0];
      out_data_r.out_y         <= res_r[1];
      out_data_r.out_z         <= res_r[2];
      out_data_r.segment_index <= seg;
      out_data_r.saturated     <= sat_r;
    end
  end

  always_comb begin
    status.last_hit  = (i_r == last_idx);
    status.next_le_t = (tm_q_r <= t_r);
    status.t1_le_t0  = (t1_r <= tm_q_r);
    status.div_done  = (cnt_r == '0);
    status.comp_last = (comp_r == 2'd2);
    status.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/kls_ctrl.sv */
// kls_ctrl: sequencer for key writes and sample requests
// drives kls_dp through kls_pkg command and status structs

module kls_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_req_type,
  output logic                  in_stall,
  input  kls_pkg::kls_status_t  status,
  output kls_pkg::kls_cmd_t     cmd
);

  kls_pkg::kls_state_t state_r;
  kls_pkg::kls_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kls_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.addr_sel = kls_pkg::ADDR_CUR;
    in_stall     = (state_r != kls_pkg::S_IDLE);
    case (state_r)
      kls_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == kls_pkg::REQ_WRITE) begin
            cmd.key_wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = kls_pkg::S_WALK_RD;
          end
        end
      end
      kls_pkg::S_WALK_RD: begin
        if (status.last_hit) begin
          state_nxt = kls_pkg::S_KEY_RD;
        end else begin
          cmd.addr_sel = kls_pkg::ADDR_NEXT;
          state_nxt    = kls_pkg::S_WALK_CMP;
        end
      end
      kls_pkg::S_WALK_CMP: begin
        if (status.next_le_t) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = kls_pkg::S_WALK_RD;
        end else begin
          cmd.t1_ld = 1'b1;
          state_nxt = kls_pkg::S_T0_RD;
        end
      end
      kls_pkg::S_T0_RD: begin
        state_nxt = kls_pkg::S_T0_CHK;
      end
      kls_pkg::S_T0_CHK: begin
        // empty or reversed segment returns the left key
        if (status.t1_le_t0) begin
          state_nxt = kls_pkg::S_KEY_RD;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = kls_pkg::S_DIV;
        end
      end
      kls_pkg::S_DIV: begin
        if (status.div_done) begin
          state_nxt = kls_pkg::S_FSAT;
        end else begin
          cmd.div_run = 1'b1;
        end
      end
      kls_pkg::S_FSAT: begin
        cmd.fsat_ld = 1'b1;
        state_nxt   = kls_pkg::S_VA_RD;
      end
      kls_pkg::S_VA_RD: begin
        cmd.a_ld     = 1'b1;
        cmd.addr_sel = kls_pkg::ADDR_NEXT;
        state_nxt    = kls_pkg::S_VB_LD;
      end
      kls_pkg::S_VB_LD: begin
        cmd.b_ld  = 1'b1;
        state_nxt = kls_pkg::S_MUL;
      end
      kls_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = kls_pkg::S_ADD;
      end
      kls_pkg::S_ADD: begin
        cmd.acc = 1'b1;
        if (status.comp_last) begin
          state_nxt = kls_pkg::S_RES_OUT;
        end else begin
          state_nxt = kls_pkg::S_MUL;
        end
      end
      kls_pkg::S_KEY_RD: begin
        state_nxt = kls_pkg::S_KEY_OUT;
      end
      kls_pkg::S_KEY_OUT: begin
        // read address stays on the key so its value holds while waiting
        if (status.out_free) begin
          cmd.emit_key = 1'b1;
          state_nxt    = kls_pkg::S_IDLE;
        end
      end
      kls_pkg::S_RES_OUT: begin
        if (status.out_free) begin
          cmd.emit_res = 1'b1;
          state_nxt    = kls_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kls_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/keyframe_linear_sampler_unit.sv */
// keyframe_linear_sampler_unit: top level of the keyframe track sampler
// instantiates kls_ctrl and kls_dp; types from kls_pkg
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   kls_pkg::in_item_t
//   out_     output     out_valid / out_stall kls_pkg::out_item_t
//   cfg_     input      cfg_we                cfg_wdata (key count)
//
// a key write is taken in S_IDLE, which it does not leave; a sample walks the
// keys up to left key i in S_WALK_RD and S_WALK_CMP, then runs the 48-step serial divider;
// a sample that returns a stored key skips the divide and multiply
// synchronous active-low reset; key stores hold no reset value
// a finished result waits in the output register while the next request
// is transferred in

module keyframe_linear_sampler_unit #(
  parameter int MAX_KEYS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  kls_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output kls_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [kls_pkg::KCNT_W-1:0]  cfg_wdata
);

  kls_pkg::kls_cmd_t    cmd;
  kls_pkg::kls_status_t status;

  kls_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_stall    (in_stall),
    .status      (status),
    .cmd         (cmd)
  );

  kls_dp #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
